### src/hcvg_pkg.sv
`default_nettype none

package hcvg_pkg;

    localparam int MAX_GRID_DEF = 256;

    localparam int COORD_W    = 8;
    localparam int H_W        = 16;
    localparam int SCALE_W    = 16;
    localparam int GRID_W     = 9;
    localparam int POS_W      = 24;
    localparam int NORM_W     = 17;
    localparam int TEX_W      = 3;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 112;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int VIDX_W     = 3;

    localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd256;
    localparam logic [GRID_W-1:0]  GRID_RST      = 9'd256;
    localparam logic [TEX_W-1:0]   TEX_PHASE_TOP = 3'd4;
    localparam logic [VIDX_W-1:0]  VIDX_LAST     = 3'd5;
    localparam logic [VIDX_W-1:0]  VIDX_SECOND_TRI = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_SCALE = 1'b0,
        CFG_GRID_SIZE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                     dx;
        logic                     dz;
    } t_corner;

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       z;
        logic signed [H_W-1:0]    h00;
        logic signed [H_W-1:0]    h10;
        logic signed [H_W-1:0]    h01;
        logic signed [H_W-1:0]    h11;
        logic signed [NORM_W-1:0] nx0;
        logic signed [NORM_W-1:0] nz0;
        logic signed [NORM_W-1:0] nx1;
        logic signed [NORM_W-1:0] nz1;
        logic [TEX_W-1:0]         row_ph;
        logic [TEX_W-1:0]         cell_ph;
    } t_cell;

    // corner offsets of the six vertices, two triangles
    function automatic t_corner corner_of(input logic [VIDX_W-1:0] idx);
        t_corner c;
        case (idx)
            3'd0:    c = '{dx: 1'b0, dz: 1'b0};
            3'd1:    c = '{dx: 1'b1, dz: 1'b0};
            3'd2:    c = '{dx: 1'b0, dz: 1'b1};
            3'd3:    c = '{dx: 1'b1, dz: 1'b1};
            3'd4:    c = '{dx: 1'b0, dz: 1'b1};
            3'd5:    c = '{dx: 1'b1, dz: 1'b0};
            default: c = '{dx: 1'b0, dz: 1'b0};
        endcase
        return c;
    endfunction

    function automatic logic [TEX_W-1:0] phase_inc(input logic [TEX_W-1:0] p);
        return (p >= TEX_PHASE_TOP) ? '0 : p + 3'd1;
    endfunction

endpackage

`default_nettype wire

### src/hcvg_cell_stage.sv
`default_nettype none

module hcvg_cell_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [hcvg_pkg::S_TDATA_W-1:0]    i_data,   // x, z, h00, h10, h01, h11
    input  wire logic                              i_first,
    input  wire logic [hcvg_pkg::GRID_W-1:0]       i_grid,
    input  wire logic                              i_release,
    output logic                                   o_cell_valid,
    output hcvg_pkg::t_cell                        o_cell
);

    logic                   r_valid;
    logic [hcvg_pkg::TEX_W-1:0] r_row_ph, r_cell_ph;
    hcvg_pkg::t_cell        r_cell, n_cell;
    logic                   w_accept;
    logic [hcvg_pkg::TEX_W-1:0] w_rp, w_cp;
    logic [hcvg_pkg::GRID_W-1:0] w_x_next;

    assign o_ready      = !r_valid || i_release;
    assign w_accept     = i_valid && o_ready;
    assign o_cell_valid = r_valid;
    assign o_cell       = r_cell;

    always_comb begin
        w_rp     = i_first ? '0 : r_row_ph;
        w_cp     = i_first ? '0 : r_cell_ph;
        w_x_next = {1'b0, i_data[7:0]} + 9'd1;

        n_cell.x       = i_data[7:0];
        n_cell.z       = i_data[15:8];
        n_cell.h00     = i_data[31:16];
        n_cell.h10     = i_data[47:32];
        n_cell.h01     = i_data[63:48];
        n_cell.h11     = i_data[79:64];
        n_cell.nx0     = 17'(signed'(i_data[31:16])) - 17'(signed'(i_data[47:32]));
        n_cell.nz0     = 17'(signed'(i_data[31:16])) - 17'(signed'(i_data[63:48]));
        n_cell.nx1     = 17'(signed'(i_data[63:48])) - 17'(signed'(i_data[79:64]));
        n_cell.nz1     = 17'(signed'(i_data[47:32])) - 17'(signed'(i_data[79:64]));
        n_cell.row_ph  = w_rp;
        n_cell.cell_ph = w_cp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_row_ph  <= '0;
            r_cell_ph <= '0;
        end else begin
            if (w_accept) begin
                r_valid   <= 1'b1;
                r_cell_ph <= hcvg_pkg::phase_inc(w_cp);
                r_row_ph  <= (w_x_next == i_grid) ? hcvg_pkg::phase_inc(w_rp) : w_rp;
            end else if (i_release) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell <= n_cell;
        end
    end

endmodule

`default_nettype wire

### src/hcvg_vertex_stage.sv
`default_nettype none

module hcvg_vertex_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cell_valid,
    input  wire hcvg_pkg::t_cell                   i_cell,
    input  wire logic [hcvg_pkg::SCALE_W-1:0]      i_scale,
    output logic                                   o_release,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [hcvg_pkg::M_TDATA_W-1:0]         o_data,
    output logic                                   o_last
);

    logic                        r_valid;
    logic [hcvg_pkg::VIDX_W-1:0] r_idx;
    logic [hcvg_pkg::M_TDATA_W-1:0] r_data, n_data;
    logic                        r_last;
    logic                        w_free, w_load;
    hcvg_pkg::t_corner           w_c;
    logic [hcvg_pkg::GRID_W-1:0] w_x9, w_z9;
    logic [24:0]                 w_px, w_pz;
    logic signed [hcvg_pkg::H_W-1:0] w_h;
    logic signed [32:0]          w_py;
    logic signed [hcvg_pkg::NORM_W-1:0] w_nx, w_nz;
    logic [hcvg_pkg::TEX_W-1:0]  w_tu, w_tv;

    assign w_free    = !r_valid || i_ready;
    assign w_load    = i_cell_valid && w_free;
    assign o_release = w_load && (r_idx == hcvg_pkg::VIDX_LAST);
    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_last    = r_last;

    always_comb begin
        w_c  = hcvg_pkg::corner_of(r_idx);
        w_x9 = {1'b0, i_cell.x} + {8'd0, w_c.dx};
        w_z9 = {1'b0, i_cell.z} + {8'd0, w_c.dz};
        w_px = w_x9 * i_scale;
        w_pz = w_z9 * i_scale;
        case ({w_c.dx, w_c.dz})
            2'b00:   w_h = i_cell.h00;
            2'b10:   w_h = i_cell.h10;
            2'b01:   w_h = i_cell.h01;
            2'b11:   w_h = i_cell.h11;
            default: w_h = i_cell.h00;
        endcase
        w_py = w_h * $signed({1'b0, i_scale});
        if (r_idx < hcvg_pkg::VIDX_SECOND_TRI) begin
            w_nx = i_cell.nx0;
            w_nz = i_cell.nz0;
        end else begin
            w_nx = i_cell.nx1;
            w_nz = i_cell.nz1;
        end
        w_tu   = i_cell.row_ph + {2'd0, w_c.dx};
        w_tv   = i_cell.cell_ph + {2'd0, w_c.dz};
        n_data = {w_tv, w_tu, w_nz, w_nx, w_pz[23:0], w_py[31:8], w_px[23:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == hcvg_pkg::VIDX_LAST) ? '0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
            r_last <= (r_idx == hcvg_pkg::VIDX_LAST);
        end
    end

endmodule

`default_nettype wire

### src/heightmap_cell_vertex_generator.sv
// Heightmap cell to vertex stream.
// Slave stream: one request per grid cell. tdata holds cell_x, cell_z,
// height_00, height_10, height_01, height_11; tuser is first_cell, which
// clears both texture phases before that cell.
// Master stream: six vertices per cell, tlast on the sixth. tdata holds
// pos_x, pos_y, pos_z, normal_x, normal_z, tex_u_fifths, tex_v_fifths.
// Config channel: index 0 vertex_scale (Q8.8), index 1 grid_size, clamped to
// MAX_GRID. Always ready; write only while the block is idle.
// A cell's first vertex passes the cell register and then the output
// register after its request is accepted. The output register carries a single
// vertex a cycle while the receiver is ready; the next cell is taken in the cycle
// its predecessor's sixth vertex is loaded, so vertices stream without gaps.
// Reset (synchronous, active low) empties both stages, sets scale 256 and
// grid 256 and clears the phases. When the receiver stalls, the output
// register holds its vertex, the held cell waits, and tready drops once
// that cell still has vertices to send.
`default_nettype none

module heightmap_cell_vertex_generator #(
    parameter int MAX_GRID = hcvg_pkg::MAX_GRID_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [7:0] cell_x, [15:8] cell_z, [31:16] height_00, [47:32] height_10,
    // [63:48] height_01, [79:64] height_11
    input  wire logic [hcvg_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] first_cell
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [88:72] normal_x,
    // [105:89] normal_z, [108:106] tex_u_fifths, [111:109] tex_v_fifths
    output logic [hcvg_pkg::M_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [hcvg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hcvg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int CW = (GW > hcvg_pkg::GRID_W) ? GW : hcvg_pkg::GRID_W;

    logic [hcvg_pkg::SCALE_W-1:0] r_scale;
    logic [hcvg_pkg::GRID_W-1:0]  r_grid;
    logic [CW-1:0]                w_g_ext, w_g_clamp;
    logic                         w_cfg_wr;
    logic                         w_release, w_cell_valid;
    hcvg_pkg::t_cell              w_cell;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_g_ext     = CW'(i_cfg_data[hcvg_pkg::GRID_W-1:0]);
    assign w_g_clamp   = (w_g_ext > CW'(MAX_GRID)) ? CW'(MAX_GRID) : w_g_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= hcvg_pkg::SCALE_RST;
            r_grid  <= hcvg_pkg::GRID_RST;
        end else if (w_cfg_wr) begin
            case (hcvg_pkg::t_cfg_idx'(i_cfg_index))
                hcvg_pkg::CFG_VERTEX_SCALE: r_scale <= i_cfg_data;
                hcvg_pkg::CFG_GRID_SIZE:    r_grid  <= w_g_clamp[hcvg_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    hcvg_cell_stage u_cell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .i_first      (i_s_axis_tuser),
        .i_grid       (r_grid),
        .i_release    (w_release),
        .o_cell_valid (w_cell_valid),
        .o_cell       (w_cell)
    );

    hcvg_vertex_stage u_vert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (w_cell_valid),
        .i_cell       (w_cell),
        .i_scale      (r_scale),
        .o_release    (w_release),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

### src/hcvg_checker.sv
`default_nettype none

module hcvg_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               o_s_axis_tready,
    input  wire logic                               o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    input  wire logic [hcvg_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  wire logic                               o_m_axis_tlast
);

    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("vertex changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("vertex valid after reset");

    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##2 o_m_axis_tvalid)
        else $error("no vertex two cycles after cell request");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[108:106] <= 3'd5)
                         && (o_m_axis_tdata[111:109] <= 3'd5))
        else $error("texture fifths out of range");

endmodule

bind heightmap_cell_vertex_generator hcvg_checker u_hcvg_checker (.*);

`default_nettype wire

### dv/tb_heightmap_cell_vertex_generator.sv
`default_nettype none

module tb_heightmap_cell_vertex_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 12;
    localparam int TIMEOUT_CYCLES  = 100_000;
    localparam int TEX_PERIOD      = 5;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int IDLE_PCT        = 9;
    localparam int HOLD_CYCLES     = 150;
    localparam int MAX_REPORTS     = 10;
    localparam int CORNER_DX [6]   = '{0, 1, 0, 1, 0, 1};
    localparam int CORNER_DZ [6]   = '{0, 0, 1, 1, 1, 0};

    localparam int H_W          = hcvg_pkg::H_W;
    localparam int COORD_W      = hcvg_pkg::COORD_W;
    localparam int TEX_W        = hcvg_pkg::TEX_W;
    localparam int NORM_W       = hcvg_pkg::NORM_W;
    localparam int POS_W        = hcvg_pkg::POS_W;
    localparam int SCALE_W      = hcvg_pkg::SCALE_W;
    localparam int GRID_W       = hcvg_pkg::GRID_W;
    localparam int CFG_DATA_W   = hcvg_pkg::CFG_DATA_W;
    localparam int M_TDATA_W    = hcvg_pkg::M_TDATA_W;
    localparam int MAX_GRID_DEF = hcvg_pkg::MAX_GRID_DEF;

    // packs straight onto i_s_axis_tdata, cell_x in the lowest bits
    typedef struct packed {
        logic signed [H_W-1:0] h11;
        logic signed [H_W-1:0] h01;
        logic signed [H_W-1:0] h10;
        logic signed [H_W-1:0] h00;
        logic [COORD_W-1:0]    z;
        logic [COORD_W-1:0]    x;
    } t_cell_req;

    // packs onto {o_m_axis_tlast, o_m_axis_tdata}
    typedef struct packed {
        logic                     last;
        logic [TEX_W-1:0]         tex_v;
        logic [TEX_W-1:0]         tex_u;
        logic signed [NORM_W-1:0] norm_z;
        logic signed [NORM_W-1:0] norm_x;
        logic [POS_W-1:0]         pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]         pos_x;
    } t_vertex;

    typedef enum logic {STEP_CFG, STEP_CELL} t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        hcvg_pkg::t_cfg_idx  idx;
        logic [CFG_DATA_W-1:0] wdata;
        t_cell_req           req;
        logic                first_cell;
        logic                pinned;
        t_vertex             v0;
    } t_step;

    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    s_valid   = 1'b0;
    t_cell_req               s_data    = '0;
    logic                    s_user    = 1'b0;
    logic                    m_ready   = 1'b0;
    logic                    cfg_valid = 1'b0;
    hcvg_pkg::t_cfg_idx      cfg_idx   = hcvg_pkg::CFG_VERTEX_SCALE;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    wire logic                 s_ready;
    wire logic                 m_valid;
    wire logic [M_TDATA_W-1:0] m_data;
    wire logic                 m_last;
    wire logic                 cfg_ready;

    // predictor state
    logic [SCALE_W-1:0] scale_r = hcvg_pkg::SCALE_RST;
    int                 grid_r  = MAX_GRID_DEF;
    logic [TEX_W-1:0]   row_ph  = '0;
    logic [TEX_W-1:0]   cell_ph = '0;
    t_vertex            pending_vertices [$];

    int  errs       = 0;
    int  n_cells    = 0;
    int  n_vertices = 0;
    int  n_writes   = 0;
    bit  calm       = 1'b0;
    bit  hold_req   = 1'b0;
    int  hold_left  = 0;

    heightmap_cell_vertex_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void predict_vertices(input t_cell_req c, input logic first_cell);
        int      hgt [2][2];
        int      nx [2];
        int      nz [2];
        int      dx;
        int      dz;
        longint  prod;
        t_vertex v;
        hgt[0][0] = int'(c.h00);
        hgt[1][0] = int'(c.h10);
        hgt[0][1] = int'(c.h01);
        hgt[1][1] = int'(c.h11);
        if (first_cell) begin
            row_ph  = '0;
            cell_ph = '0;
        end
        nx[0] = hgt[0][0] - hgt[1][0];
        nz[0] = hgt[0][0] - hgt[0][1];
        nx[1] = hgt[0][1] - hgt[1][1];
        nz[1] = hgt[1][0] - hgt[1][1];
        for (int i = 0; i < 6; i++) begin
            dx       = CORNER_DX[i];
            dz       = CORNER_DZ[i];
            prod     = longint'(hgt[dx][dz]) * longint'(scale_r);
            v.pos_x  = POS_W'((int'(c.x) + dx) * int'(scale_r));
            v.pos_y  = POS_W'(prod >>> 8);
            v.pos_z  = POS_W'((int'(c.z) + dz) * int'(scale_r));
            v.norm_x = NORM_W'(nx[i / 3]);
            v.norm_z = NORM_W'(nz[i / 3]);
            v.tex_u  = TEX_W'(int'(row_ph) + dx);
            v.tex_v  = TEX_W'(int'(cell_ph) + dz);
            v.last   = (i == 5);
            pending_vertices.push_back(v);
        end
        cell_ph = TEX_W'((int'(cell_ph) + 1) % TEX_PERIOD);
        if (int'(c.x) + 1 == grid_r)
            row_ph = TEX_W'((int'(row_ph) + 1) % TEX_PERIOD);
    endfunction

    function automatic t_cell_req mk_req(input int x, input int z, input int h00,
                                         input int h10, input int h01, input int h11);
        t_cell_req r;
        r.x   = COORD_W'(x);
        r.z   = COORD_W'(z);
        r.h00 = H_W'(h00);
        r.h10 = H_W'(h10);
        r.h01 = H_W'(h01);
        r.h11 = H_W'(h11);
        return r;
    endfunction

    function automatic t_vertex vtx(input int px, input int py, input int pz,
                                    input int nx, input int nz, input int u, input int v);
        t_vertex r;
        r.pos_x  = POS_W'(px);
        r.pos_y  = POS_W'(py);
        r.pos_z  = POS_W'(pz);
        r.norm_x = NORM_W'(nx);
        r.norm_z = NORM_W'(nz);
        r.tex_u  = TEX_W'(u);
        r.tex_v  = TEX_W'(v);
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_step cfg_step(input hcvg_pkg::t_cfg_idx idx,
                                       input logic [CFG_DATA_W-1:0] d);
        t_step s;
        s       = '0;
        s.kind  = STEP_CFG;
        s.idx   = idx;
        s.wdata = d;
        return s;
    endfunction

    function automatic t_step cell_step(input t_cell_req r, input logic f);
        t_step s;
        s            = '0;
        s.kind       = STEP_CELL;
        s.req        = r;
        s.first_cell = f;
        return s;
    endfunction

    function automatic t_step pinned_step(input t_cell_req r, input logic f, input t_vertex v);
        t_step s;
        s        = cell_step(r, f);
        s.pinned = 1'b1;
        s.v0     = v;
        return s;
    endfunction

    function automatic logic [H_W-1:0] rand_height();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return H_W'($urandom);
        endcase
    endfunction

    // one request, with a random gap in front unless calm
    task automatic drive_cell(input t_cell_req r, input logic f);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= r;
        s_user  <= f;
        do @(posedge i_clk); while (!s_ready);
        predict_vertices(r, f);
        n_cells++;
    endtask

    // sender stops until every vertex owed has arrived
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input hcvg_pkg::t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hcvg_pkg::CFG_VERTEX_SCALE: scale_r = d;
            hcvg_pkg::CFG_GRID_SIZE:    grid_r  = (d[GRID_W-1:0] > MAX_GRID_DEF) ?
                                                  MAX_GRID_DEF : int'(d[GRID_W-1:0]);
            default: ;
        endcase
        n_writes++;
    endtask

    // receiver: random back-pressure, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (i_rst_n && m_valid && m_ready) begin
            got = {m_last, m_data};
            n_vertices++;
            if (pending_vertices.size() == 0) begin
                errs++;
                if (errs <= MAX_REPORTS)
                    $display("vertex %0d: nothing expected, got %h", n_vertices, got);
            end else begin
                want = pending_vertices.pop_front();
                if (got !== want) begin
                    errs++;
                    if (errs <= MAX_REPORTS) begin
                        $display("vertex %0d exp: px=%0d py=%0d pz=%0d nx=%0d nz=%0d u=%0d v=%0d last=%0b",
                                 n_vertices, want.pos_x, want.pos_y, want.pos_z, want.norm_x,
                                 want.norm_z, want.tex_u, want.tex_v, want.last);
                        $display("vertex %0d got: px=%0d py=%0d pz=%0d nx=%0d nz=%0d u=%0d v=%0d last=%0b",
                                 n_vertices, got.pos_x, got.pos_y, got.pos_z, got.norm_x,
                                 got.norm_z, got.tex_u, got.tex_v, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d vertices outstanding", pending_vertices.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_step            plan [$];
        logic [15:0]      phase_scale [N_PHASES];
        logic [15:0]      phase_grid [N_PHASES];
        t_cell_req        req;
        logic             first_f;
        int               walk_w;
        int               cur_x;
        int               cur_z;
        int               g;

        // reset config: scale 1.0, grid 256
        plan.push_back(pinned_step(mk_req(0, 0, 0, 0, 0, 0), 1'b1, vtx(0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(pinned_step(mk_req(255, 255, 32767, -32768, -32768, 32767), 1'b1,
                                   vtx(65280, 32767, 65280, 65535, 65535, 0, 0)));
        // x 255 ended the row, both phases now one
        plan.push_back(pinned_step(mk_req(255, 255, -32768, 32767, 32767, -32768), 1'b0,
                                   vtx(65280, -32768, 65280, -65535, -65535, 1, 1)));
        plan.push_back(cell_step(mk_req(3, 7, -1, 1, -256, 255), 1'b0));
        // half scale: negative heights floor
        plan.push_back(cfg_step(hcvg_pkg::CFG_VERTEX_SCALE, 16'd128));
        plan.push_back(cell_step(mk_req(10, 20, -1, -2, 1, 3), 1'b0));
        plan.push_back(cell_step(mk_req(11, 20, -32768, 32767, -257, 0), 1'b0));
        // grid of one: every cell ends a row, row phase wraps
        plan.push_back(cfg_step(hcvg_pkg::CFG_GRID_SIZE, 16'd1));
        plan.push_back(cell_step(mk_req(0, 0, 100, 200, 300, 400), 1'b1));
        for (int i = 1; i < 6; i++)
            plan.push_back(cell_step(mk_req(0, i, -i, i, 2 * i, -3 * i), 1'b0));
        // grid zero never ends a row
        plan.push_back(cfg_step(hcvg_pkg::CFG_GRID_SIZE, 16'd0));
        plan.push_back(cell_step(mk_req(255, 9, 5, 6, 7, 8), 1'b0));
        // oversize grid clamps to 256
        plan.push_back(cfg_step(hcvg_pkg::CFG_GRID_SIZE, 16'd300));
        plan.push_back(cell_step(mk_req(255, 9, 5, 6, 7, 8), 1'b0));
        plan.push_back(cfg_step(hcvg_pkg::CFG_VERTEX_SCALE, 16'hFFFF));
        plan.push_back(pinned_step(mk_req(255, 255, -32768, 32767, 32767, 0), 1'b1,
                                   vtx(16711425, -8388480, 16711425, -65535, -65535, 0, 0)));
        plan.push_back(cfg_step(hcvg_pkg::CFG_VERTEX_SCALE, 16'd0));
        plan.push_back(pinned_step(mk_req(200, 100, 1000, 0, 0, 0), 1'b1,
                                   vtx(0, 0, 0, 1000, 1000, 0, 0)));
        plan.push_back(cfg_step(hcvg_pkg::CFG_VERTEX_SCALE, 16'd256));
        plan.push_back(cfg_step(hcvg_pkg::CFG_GRID_SIZE, 16'd256));

        phase_scale = '{16'd256, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'd256};
        phase_grid  = '{16'd8, 16'd1, 16'd0, 16'hFE05, 16'd300,
                        16'($urandom_range(1, 12)), 16'd256};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) begin
                write_reg(plan[i].idx, plan[i].wdata);
            end else begin
                drive_cell(plan[i].req, plan[i].first_cell);
                if (plan[i].pinned)
                    pending_vertices[pending_vertices.size() - 6] = plan[i].v0;
            end
        end

        cur_x = 0;
        cur_z = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(hcvg_pkg::CFG_VERTEX_SCALE, phase_scale[p]);
            write_reg(hcvg_pkg::CFG_GRID_SIZE, phase_grid[p]);
            g      = int'(phase_grid[p][GRID_W-1:0]);
            walk_w = (g == 0 || g > MAX_GRID_DEF) ? MAX_GRID_DEF : g;
            calm   = (p == 2);
            // receiver stalls while requests keep coming
            if (p == 1)
                hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                    settle();
                if (k > 0 && $urandom_range(0, 99) < 15) begin
                    req = mk_req($urandom_range(0, 255), $urandom_range(0, 255), rand_height(),
                                 rand_height(), rand_height(), rand_height());
                    first_f = 1'($urandom_range(0, 1));
                end else begin
                    // walk the grid row by row, new mesh now and then
                    first_f = (k == 0 || $urandom_range(0, 29) == 0);
                    if (first_f) begin
                        cur_z = int'($urandom_range(0, 255));
                        if ($urandom_range(0, 1) == 1)
                            cur_x = walk_w - 1 -
                                    int'($urandom_range(0, (walk_w > 6) ? 6 : walk_w - 1));
                        else
                            cur_x = int'($urandom_range(0, walk_w - 1));
                    end
                    req = mk_req(cur_x, cur_z, rand_height(), rand_height(), rand_height(),
                                 rand_height());
                    cur_x++;
                    if (cur_x == walk_w) begin
                        cur_x = 0;
                        cur_z = (cur_z + 1) % 256;
                    end
                end
                drive_cell(req, first_f);
            end
        end
        calm = 1'b0;

        settle();
        if (pending_vertices.size() != 0) begin
            errs++;
            $display("%0d vertices never arrived", pending_vertices.size());
        end
        $display("%0d cells sent, %0d vertices checked, %0d register writes, %0d errors",
                 n_cells, n_vertices, n_writes, errs);
        $display("covered: scale 0/0.5/1/max and random, grid 0/1/5/8/256/clamped, phase wrap");
        if (errs == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
